[hdl/wpsp_pkg.sv]
// wpsp_pkg: shared types and constants of the wav pcm stream parser
// used by every module in hdl; depends on nothing

package wpsp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] PCM_BITS  = 16'd16;
  localparam logic [15:0] MAX_CHAN  = 16'd2;
  localparam logic [31:0] FMT_MIN   = 32'd16;
  localparam logic [4:0]  FMT_SPAN  = 5'd16;
  localparam logic [3:0]  BITS_OFS  = 4'd14;

  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [6:0] VOL_RESET = 7'd80;
  localparam logic [6:0] VOL_FULL  = 7'd100;

  // divide by 100 as multiply by reciprocal plus one correction step
  localparam int unsigned   RECIP_SHIFT = 22;
  localparam logic [15:0]   RECIP_MUL   = 16'((64'd1 << RECIP_SHIFT) / 64'd100);
  localparam logic [22:0]   DIVISOR     = 23'd100;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [15:0] sample;
    logic [1:0]        channels;
    logic [31:0]       rate_hz;
    logic              last;
  } out_t;

  // classified result before scaling
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] raw;
    logic [1:0]  channels;
    logic [31:0] rate_hz;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } slot_t;

endpackage

[hdl/wav_pcm_stream_parser_top.sv]
// wav_pcm_stream_parser_top: parser front, result queue and scaler back
// depends on wpsp_pkg, wpsp_front, wpsp_queue, wpsp_back
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   wpsp_pkg::in_t
//   out      source     out_valid_o/out_stall_i wpsp_pkg::out_t
//   cfg      sink       cfg_we_i                cfg_wdata_i, volume in percent
//
// one file byte per cycle unless in_stall_o; the parser state machine handles each byte
// a result passes the queue head, then the multiply, reciprocal and correct registers
// in_stall_o rises only when the queue is full behind a stalled output
// reset clears parse state except the held low byte and sets the volume to 80 percent

module wav_pcm_stream_parser_top #(
  parameter int unsigned QueueDepth = wpsp_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wpsp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wpsp_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i
);
  import wpsp_pkg::*;

  slot_t push, head;
  logic  full, pop;

  wpsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push)
  );

  wpsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  wpsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/wpsp_front.sv]
// wpsp_front: byte parser for riff/wave headers, chunk walk and pcm byte pairing
// depends on wpsp_pkg

module wpsp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  wpsp_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  input  logic           full_i,
  output wpsp_pkg::slot_t push_o
);
  import wpsp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF  = 3'd0,
    PH_RSIZE = 3'd1,
    PH_WAVE  = 3'd2,
    PH_HDR   = 3'd3,
    PH_BODY  = 3'd4,
    PH_PAD   = 3'd5,
    PH_DATA  = 3'd6,
    PH_WAIT  = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] left_q, left_d;
  logic [7:0]  low_q, low_d;
  logic        half_q, half_d;

  logic        accept;
  logic [7:0]  b;
  slot_t       res;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign b          = in_data_i.file_byte;
  assign push_o     = res;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    tag_d   = tag_q;
    len_d   = len_q;
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    left_d  = left_q;
    low_d   = low_q;
    half_d  = half_q;
    res     = '0;
    if (accept) begin
      case (phase_q)
        PH_RIFF, PH_WAVE: begin
          tag_d = {tag_q[23:0], b};
          pos_d = pos_q + 5'd1;
          if (pos_d >= 5'd4) begin
            if (tag_d != ((phase_q == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
              res.valid     = 1'b1;
              res.item.kind = KIND_ERROR;
              res.item.last = 1'b1;
              phase_d       = PH_WAIT;
            end else begin
              phase_d = (phase_q == PH_RIFF) ? PH_RSIZE : PH_HDR;
              tag_d   = '0;
              len_d   = '0;
            end
            pos_d = '0;
          end
        end
        PH_RSIZE: begin
          pos_d = pos_q + 5'd1;
          if (pos_d >= 5'd4) begin
            phase_d = PH_WAVE;
            pos_d   = '0;
            tag_d   = '0;
          end
        end
        PH_HDR: begin
          if (pos_q < 5'd4) begin
            tag_d = {tag_q[23:0], b};
          end else begin
            case (pos_q[1:0])
              2'd0:    len_d[7:0]   = b;
              2'd1:    len_d[15:8]  = b;
              2'd2:    len_d[23:16] = b;
              default: len_d[31:24] = b;
            endcase
          end
          pos_d = pos_q + 5'd1;
          if (pos_d >= 5'd8) begin
            pos_d = '0;
            if (tag_d == TAG_DATA) begin
              res.valid = 1'b1;
              if (fmt_q == FMT_PCM && bits_q == PCM_BITS && len_d != '0
                  && chan_q <= MAX_CHAN) begin
                res.item.kind     = KIND_FORMAT;
                res.item.channels = chan_q[1:0];
                res.item.rate_hz  = rate_q;
                left_d            = len_d;
                half_d            = 1'b0;
                phase_d           = PH_DATA;
              end else begin
                res.item.kind = KIND_ERROR;
                res.item.last = 1'b1;
                phase_d       = PH_WAIT;
              end
            end else if (len_d == '0) begin
              tag_d = '0;
            end else begin
              left_d  = len_d;
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (tag_q == TAG_FMT && len_q >= FMT_MIN && pos_q < FMT_SPAN) begin
            if (pos_q[3:1] == 3'd0) begin
              if (pos_q[0]) fmt_d[15:8] = b;
              else          fmt_d[7:0]  = b;
            end else if (pos_q[3:1] == 3'd1) begin
              if (pos_q[0]) chan_d[15:8] = b;
              else          chan_d[7:0]  = b;
            end else if (pos_q[3:2] == 2'd1) begin
              case (pos_q[1:0])
                2'd0:    rate_d[7:0]   = b;
                2'd1:    rate_d[15:8]  = b;
                2'd2:    rate_d[23:16] = b;
                default: rate_d[31:24] = b;
              endcase
            end else if (pos_q[3:1] == BITS_OFS[3:1]) begin
              if (pos_q[0]) bits_d[15:8] = b;
              else          bits_d[7:0]  = b;
            end
          end
          if (pos_q < FMT_SPAN) pos_d = pos_q + 5'd1;
          left_d = left_q - 32'd1;
          if (left_d == '0) begin
            pos_d = '0;
            if (len_q[0]) begin
              phase_d = PH_PAD;
            end else begin
              phase_d = PH_HDR;
              tag_d   = '0;
              len_d   = '0;
            end
          end
        end
        PH_PAD: begin
          phase_d = PH_HDR;
          pos_d   = '0;
          tag_d   = '0;
          len_d   = '0;
        end
        PH_DATA: begin
          left_d = left_q - 32'd1;
          if (half_q) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_SAMPLE;
            res.item.raw  = {b, low_q};
            half_d        = 1'b0;
          end else begin
            low_d  = b;
            half_d = 1'b1;
          end
          if (left_d == '0) begin
            if (!res.valid) begin
              res.valid     = 1'b1;
              res.item.kind = KIND_END;
            end
            res.item.last = 1'b1;
            phase_d       = PH_WAIT;
          end
        end
        default: begin
        end
      endcase

      if (in_data_i.end_of_file) begin
        if (phase_d < PH_DATA) begin
          res.valid = 1'b1;
          res.item  = '0;
          res.item.kind = KIND_ERROR;
          res.item.last = 1'b1;
        end else if (phase_d == PH_DATA) begin
          if (!res.valid) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_END;
          end
          res.item.last = 1'b1;
        end
        // rearm for the next file
        phase_d = PH_RIFF;
        pos_d   = '0;
        tag_d   = '0;
        len_d   = '0;
        fmt_d   = '0;
        chan_d  = '0;
        rate_d  = '0;
        bits_d  = '0;
        left_d  = '0;
        low_d   = '0;
        half_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      pos_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      left_q  <= '0;
      half_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      fmt_q   <= fmt_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      left_q  <= left_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
  end

endmodule

[hdl/wpsp_queue.sv]
// wpsp_queue: short result queue between parser and scaler
// depends on wpsp_pkg

module wpsp_queue #(
  parameter int unsigned Depth = wpsp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wpsp_pkg::slot_t push_i,
  output logic            full_o,
  input  logic            pop_i,
  output wpsp_pkg::slot_t head_o
);
  import wpsp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntFull);
  assign do_push      = push_i.valid & ~full_o;
  assign do_pop       = pop_i & (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.item;
  end

endmodule

[hdl/wpsp_back.sv]
// wpsp_back: volume register and three stage sample scaler with output register
// depends on wpsp_pkg

module wpsp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  input  wpsp_pkg::slot_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output wpsp_pkg::out_t  out_data_o
);
  import wpsp_pkg::*;

  logic [6:0]  vol_q, vol_eff;

  logic        v1_q, v2_q, v3_q;
  logic        en1, en2, en3;
  item_t       it1_q, it2_q;
  logic signed [23:0] prod_d, prod_q;
  logic [23:0] mag24;
  logic [21:0] mag_d, mag_q;
  logic        neg_d, neg_q;
  logic [37:0] recip;
  logic [15:0] q0_d, q0_q;
  logic [22:0] back_mul, rem;
  logic [15:0] quo;
  out_t        res_d, res_q;

  assign en3   = ~v3_q | ~out_stall_i;
  assign en2   = ~v2_q | en3;
  assign en1   = ~v1_q | en2;
  assign pop_o = en1;

  assign out_valid_o = v3_q;
  assign out_data_o  = res_q;

  // stage 1: gain multiply, full volume passes unchanged
  assign vol_eff = (vol_q >= VOL_FULL) ? VOL_FULL : vol_q;
  assign prod_d  = $signed(head_i.item.raw) * $signed({1'b0, vol_eff});

  // stage 2: magnitude and reciprocal estimate
  assign neg_d = prod_q[23];
  assign mag24 = neg_d ? 24'(-prod_q) : 24'(prod_q);
  assign mag_d = mag24[21:0];
  assign recip = 38'(mag_d) * 38'(RECIP_MUL);
  assign q0_d  = recip[RECIP_SHIFT +: 16];

  // stage 3: one correction step and sign restore
  assign back_mul = 23'(q0_q) * DIVISOR;
  assign rem      = {1'b0, mag_q} - back_mul;
  assign quo      = q0_q + ((rem >= DIVISOR) ? 16'd1 : 16'd0);

  always_comb begin
    res_d.kind     = it2_q.kind;
    res_d.channels = it2_q.channels;
    res_d.rate_hz  = it2_q.rate_hz;
    res_d.last     = it2_q.last;
    res_d.sample   = neg_q ? $signed(16'd0 - quo) : $signed(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= VOL_RESET;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cfg_we_i) vol_q <= cfg_wdata_i;
      if (en1) v1_q <= head_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      it1_q  <= head_i.item;
      prod_q <= prod_d;
    end
    if (en2) begin
      it2_q <= it1_q;
      neg_q <= neg_d;
      mag_q <= mag_d;
      q0_q  <= q0_d;
    end
    if (en3) res_q <= res_d;
  end

endmodule

[tb/sv/wav_parse_checker.sv]
`timescale 1ns / 1ps
// wav_parse_checker: follows the wav parser byte by byte, predicts each result
// from the accepted requests and the volume writes, and compares results in order
// depends on wpsp_pkg

module wav_parse_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  wpsp_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  wpsp_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             checked_o
);
  import wpsp_pkg::*;

  localparam int PERCENT = 100;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_HDR, PH_BODY, PH_PAD, PH_DATA, PH_WAIT
  } parse_phase_e;

  parse_phase_e phase;
  logic [31:0]  field_pos;
  logic [31:0]  tag_word;
  logic [31:0]  body_len;
  logic [31:0]  bytes_left;
  logic [31:0]  sample_hz;
  logic [15:0]  fmt_code;
  logic [15:0]  chan_count;
  logic [15:0]  sample_width;
  logic [7:0]   held_byte;
  logic         have_low;
  logic [6:0]   volume;

  out_t parsed_results_q[$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    checked_o = 0;
  end

  task automatic clear_parse();
    phase = PH_RIFF;
    field_pos = '0;
    tag_word = '0;
    body_len = '0;
    bytes_left = '0;
    sample_hz = '0;
    fmt_code = '0;
    chan_count = '0;
    sample_width = '0;
    held_byte = '0;
    have_low = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
             $realtime, checked_o, what, got_v, want_v);
    fail_count_o++;
  endtask

  task automatic parse_file_byte(input in_t req);
    logic [7:0]  b;
    logic [15:0] raw;
    int          scaled;
    bit          got;
    out_t        res;
    b = req.file_byte;
    got = 1'b0;
    res = '0;
    case (phase)
      PH_RIFF, PH_WAVE: begin
        tag_word = {tag_word[23:0], b};
        field_pos++;
        if (field_pos >= 4) begin
          if (tag_word != ((phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
            got = 1'b1;
            res.kind = KIND_ERROR;
            res.last = 1'b1;
            phase = PH_WAIT;
          end else begin
            phase = (phase == PH_RIFF) ? PH_RSIZE : PH_HDR;
            tag_word = '0;
            body_len = '0;
          end
          field_pos = '0;
        end
      end
      PH_RSIZE: begin
        field_pos++;
        if (field_pos >= 4) begin
          phase = PH_WAVE;
          field_pos = '0;
          tag_word = '0;
        end
      end
      PH_HDR: begin
        if (field_pos < 4) tag_word = {tag_word[23:0], b};
        else body_len[(field_pos - 4) * 8 +: 8] = b;
        field_pos++;
        if (field_pos >= 8) begin
          field_pos = '0;
          if (tag_word == TAG_DATA) begin
            got = 1'b1;
            if (fmt_code == FMT_PCM && sample_width == PCM_BITS && body_len != 0 &&
                chan_count <= MAX_CHAN) begin
              res.kind = KIND_FORMAT;
              res.channels = chan_count[1:0];
              res.rate_hz = sample_hz;
              bytes_left = body_len;
              have_low = 1'b0;
              phase = PH_DATA;
            end else begin
              res.kind = KIND_ERROR;
              res.last = 1'b1;
              phase = PH_WAIT;
            end
          end else if (body_len == 0) begin
            tag_word = '0;
          end else begin
            bytes_left = body_len;
            phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (tag_word == TAG_FMT && body_len >= FMT_MIN && field_pos < FMT_SPAN) begin
          if (field_pos < 2) fmt_code[field_pos * 8 +: 8] = b;
          else if (field_pos < 4) chan_count[(field_pos - 2) * 8 +: 8] = b;
          else if (field_pos < 8) sample_hz[(field_pos - 4) * 8 +: 8] = b;
          else if (field_pos >= BITS_OFS)
            sample_width[(field_pos - BITS_OFS) * 8 +: 8] = b;
        end
        if (field_pos < FMT_SPAN) field_pos++;
        bytes_left--;
        if (bytes_left == 0) begin
          field_pos = '0;
          if (body_len[0]) begin
            phase = PH_PAD;
          end else begin
            phase = PH_HDR;
            tag_word = '0;
            body_len = '0;
          end
        end
      end
      PH_PAD: begin
        phase = PH_HDR;
        field_pos = '0;
        tag_word = '0;
        body_len = '0;
      end
      PH_DATA: begin
        bytes_left--;
        if (have_low) begin
          raw = {b, held_byte};
          scaled = int'($signed(raw));
          if (volume < VOL_FULL) scaled = scaled * int'(volume) / PERCENT;
          res.sample = scaled[15:0];
          res.kind = KIND_SAMPLE;
          got = 1'b1;
          have_low = 1'b0;
        end else begin
          held_byte = b;
          have_low = 1'b1;
        end
        if (bytes_left == 0) begin
          if (!got) begin
            got = 1'b1;
            res.kind = KIND_END;
          end
          res.last = 1'b1;
          phase = PH_WAIT;
        end
      end
      default: begin
      end
    endcase

    if (req.end_of_file) begin
      if (phase < PH_DATA) begin
        got = 1'b1;
        res = '0;
        res.kind = KIND_ERROR;
        res.last = 1'b1;
      end else if (phase == PH_DATA) begin
        if (!got) begin
          got = 1'b1;
          res.kind = KIND_END;
        end
        res.last = 1'b1;
      end
      clear_parse();
    end

    if (got) parsed_results_q.push_back(res);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (parsed_results_q.size() == 0) begin
      report_mismatch("result with none expected, kind", 32'(got.kind), 32'h0);
    end else begin
      want = parsed_results_q.pop_front();
      checked_o++;
      if (got.kind != want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.sample != want.sample)
        report_mismatch("sample", 32'(got.sample), 32'(want.sample));
      if (got.channels != want.channels)
        report_mismatch("channels", 32'(got.channels), 32'(want.channels));
      if (got.rate_hz != want.rate_hz)
        report_mismatch("rate_hz", got.rate_hz, want.rate_hz);
      if (got.last != want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      volume = VOL_RESET;
      parsed_results_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) parse_file_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (cfg_we_i) volume = cfg_wdata_i;
      pending_o <= parsed_results_q.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench: feeds generated wav files byte by byte into wav_pcm_stream_parser_top
// under several volume settings with random idling on both channels
// depends on wpsp_pkg, wav_parse_checker and the parser rtl

module testbench;
  import wpsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_GAP   = 12;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned NUM_PHASES  = 8;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  int          fail_count;
  int          pending_count;
  int          checked_count;
  bit          quiet;
  bit          hold_req;
  int unsigned items_sent;
  int unsigned files_sent;
  int unsigned cycle_count;
  logic [7:0]  wav_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wav_pcm_stream_parser_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  wav_parse_checker parse_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count)
  );

  task automatic push_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) wav_bytes.push_back(t[i * 8 +: 8]);
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) wav_bytes.push_back(v[i * 8 +: 8]);
  endtask

  task automatic add_other_chunk();
    int unsigned len;
    len = $urandom_range(0, 6);
    push_tag($urandom);
    push_le(len, 4);
    repeat (len) wav_bytes.push_back(8'($urandom));
    if (len % 2 == 1) wav_bytes.push_back(8'($urandom));
  endtask

  task automatic build_wav();
    logic [7:0]   extreme_bytes[6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    int unsigned  clen, dcount, idx, cut;
    logic [31:0]  dlen, rate;
    logic [15:0]  fcode, chans, bits;
    logic [127:0] fmt_body;
    wav_bytes.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 20)) wav_bytes.push_back(8'($urandom));
      return;
    end
    push_tag(TAG_RIFF);
    push_le($urandom, 4);
    push_tag(TAG_WAVE);
    if ($urandom_range(0, 19) == 0) begin
      idx = $urandom_range(0, 3) + 8 * $urandom_range(0, 1);
      wav_bytes[idx] = wav_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    repeat ($urandom_range(0, 2)) add_other_chunk();
    if ($urandom_range(0, 24) == 0) begin
      // long chunk cut short by the end of the file
      push_tag($urandom);
      push_le($urandom | 32'h0100_0000, 4);
      repeat ($urandom_range(0, 6)) wav_bytes.push_back(8'($urandom));
      return;
    end
    if ($urandom_range(0, 11) != 0) begin
      case ($urandom_range(0, 7))
        0: clen = 14;
        1: clen = 17;
        2: clen = 18;
        3: clen = 24;
        default: clen = 16;
      endcase
      fcode = ($urandom_range(0, 9) != 0) ? FMT_PCM : 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: chans = 16'd1;
        4, 5, 6, 7: chans = 16'd2;
        8: chans = 16'($urandom_range(0, 3));
        default: chans = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: rate = 32'd8000;
        1: rate = 32'd44100;
        2: rate = 32'd48000;
        default: rate = $urandom;
      endcase
      if ($urandom_range(0, 9) != 0) bits = PCM_BITS;
      else bits = $urandom_range(0, 1) ? 16'd24 : 16'($urandom);
      fmt_body = {bits, 16'($urandom), $urandom, rate, chans, fcode};
      push_tag(TAG_FMT);
      push_le(clen, 4);
      for (int i = 0; i < clen; i++)
        wav_bytes.push_back((i < 16) ? fmt_body[i * 8 +: 8] : 8'($urandom));
      if (clen % 2 == 1) wav_bytes.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 1)) add_other_chunk();
    push_tag(TAG_DATA);
    case ($urandom_range(0, 19))
      0: dlen = 32'd0;
      1: dlen = $urandom | 32'h8000_0000;
      default: dlen = $urandom_range(1, 30);
    endcase
    push_le(dlen, 4);
    if (dlen > 64) begin
      dcount = $urandom_range(0, 12);
    end else begin
      case ($urandom_range(0, 9))
        0: dcount = 0;
        1: dcount = (dlen == 0) ? 0 : $urandom_range(0, dlen - 1);
        2: dcount = dlen + $urandom_range(1, 4);
        default: dcount = dlen;
      endcase
    end
    repeat (dcount)
      wav_bytes.push_back(($urandom_range(0, 3) == 0) ? extreme_bytes[$urandom_range(0, 5)]
                                                        : 8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, wav_bytes.size());
      while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
    end
  endtask

  task automatic drive_request(input in_t req);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_wav();
    in_t req;
    for (int i = 0; i < wav_bytes.size(); i++) begin
      req.file_byte = wav_bytes[i];
      req.end_of_file = (i == wav_bytes.size() - 1);
      drive_request(req);
    end
    files_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic set_volume(input logic [6:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    bit          stall_val;
    int unsigned run_len;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        stall_val = 1'b1;
        run_len = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_val = 1'b1;
        run_len = $urandom_range(1, 5);
      end else begin
        stall_val = 1'b0;
        run_len = $urandom_range(1, 8);
      end
      @(negedge clk);
      out_stall <= stall_val;
      repeat (run_len - 1) @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("wav_pcm_stream_parser_top: mismatch");
    $finish;
  end

  initial begin
    logic [6:0]  vol_plan[NUM_PHASES];
    int unsigned phase_start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    files_sent = 0;
    vol_plan = '{7'd100, 7'd0, 7'd127, 7'd99, 7'd1, 7'd50, 7'd80, 7'd80};
    vol_plan[5] = 7'($urandom_range(2, 98));
    vol_plan[6] = 7'($urandom_range(0, 127));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end inside the header on the first byte
    wav_bytes.delete();
    wav_bytes.push_back(8'h52);
    send_wav();
    // bad riff tag, then ignored bytes
    wav_bytes.delete();
    push_tag(32'h5249_4658);
    wav_bytes.push_back(8'hFF);
    wav_bytes.push_back(8'h00);
    send_wav();
    // bad wave tag on the final byte
    wav_bytes.delete();
    push_tag(TAG_RIFF);
    push_le(32'hFF00_FF00, 4);
    push_tag(32'h5741_5646);
    send_wav();
    wav_bytes.delete();
    wav_bytes.push_back(8'hFF);
    wav_bytes.push_back(8'h00);
    send_wav();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_volume(vol_plan[p]);
      quiet = (p == NUM_PHASES - 1);
      if (p == 3) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_wav();
        send_wav();
        if (p == 5 || (!quiet && p != 3 && $urandom_range(0, 9) == 0)) wait_drained();
      end
    end
    wait_drained();

    $display("%0d file bytes in %0d files over %0d volume settings, %0d results checked",
             items_sent, files_sent, NUM_PHASES + 1, checked_count);
    if (fail_count == 0) begin
      $display("wav_pcm_stream_parser_top: match");
    end else begin
      $display("wav_pcm_stream_parser_top: mismatch");
    end
    $finish;
  end

endmodule
